/* design/scancode_to_keys_decoder_macros.svh */
// assertion macros shared by the scan code decoder modules
`ifndef SCANCODE_TO_KEYS_DECODER_MACROS_SVH
`define SCANCODE_TO_KEYS_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scd assertion failed");

// next-cycle implication, disabled while reset is low
`define SCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scd assertion failed");

`endif

/* design/scd_pkg.sv */
// package with shared types, codes and keymap functions of the scan code decoder
package scd_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int MAX_CHARS = 4;
    localparam int CIDX_W = $clog2(MAX_CHARS);

    // scan codes
    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_ALT    = 7'h38;
    localparam logic [6:0] SC_LMETA  = 7'h5B;
    localparam logic [6:0] SC_RMETA  = 7'h5C;
    localparam logic [6:0] SC_ESC    = 7'h01;
    localparam logic [6:0] SC_F4     = 7'h3E;
    localparam logic [6:0] SC_UP     = 7'h48;
    localparam logic [6:0] SC_DOWN   = 7'h50;
    localparam logic [6:0] SC_RIGHT  = 7'h4D;
    localparam logic [6:0] SC_LEFT   = 7'h4B;
    localparam logic [6:0] SC_HOME   = 7'h47;
    localparam logic [6:0] SC_END    = 7'h4F;
    localparam logic [6:0] SC_DEL    = 7'h53;

    // extended key codes
    localparam logic [8:0] KEY_UP    = 9'd256;
    localparam logic [8:0] KEY_DOWN  = 9'd257;
    localparam logic [8:0] KEY_RIGHT = 9'd258;
    localparam logic [8:0] KEY_LEFT  = 9'd259;
    localparam logic [8:0] KEY_HOME  = 9'd260;
    localparam logic [8:0] KEY_END   = 9'd261;
    localparam logic [8:0] KEY_DEL   = 9'd262;

    // character codes
    localparam logic [7:0] CH_ESC        = 8'h1B;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_TILDE      = 8'h7E;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_A_LOWER    = 8'h61;
    localparam logic [7:0] CH_Z_LOWER    = 8'h7A;
    localparam logic [7:0] CH_CTRL_BIAS  = 8'h60;
    localparam logic [7:0] CH_CASE_BIAS  = 8'h20;
    localparam logic [7:0] CH_CTRL_SPACE = 8'h1F;
    localparam logic [7:0] CH_CTRL_LBR   = 8'h1B;
    localparam logic [7:0] CH_CTRL_BSL   = 8'h1C;
    localparam logic [7:0] CH_CTRL_RBR   = 8'h1D;
    localparam logic [7:0] CH_ALT_TAB    = 8'h1E;
    localparam logic [7:0] CH_ALT_STAB   = 8'h81;
    localparam logic [7:0] CH_ALT_F4     = 8'h80;
    localparam logic [7:0] CH_META_LEFT  = 8'h82;
    localparam logic [7:0] CH_META_RIGHT = 8'h83;
    localparam logic [7:0] CH_META_UP    = 8'h84;
    localparam logic [7:0] CH_META_DOWN  = 8'h85;
    localparam logic [7:0] CH_CAE        = 8'h86;
    localparam logic [7:0] CH_META_TAP   = 8'h87;
    localparam logic [7:0] CH_FIN_UP     = 8'h41;
    localparam logic [7:0] CH_FIN_DOWN   = 8'h42;
    localparam logic [7:0] CH_FIN_RIGHT  = 8'h43;
    localparam logic [7:0] CH_FIN_LEFT   = 8'h44;
    localparam logic [7:0] CH_FIN_HOME   = 8'h48;
    localparam logic [7:0] CH_FIN_END    = 8'h46;
    localparam logic [7:0] CH_FIN_DEL    = 8'h33;

    // one decoded run: optional key event, then up to four characters
    typedef struct packed {
        logic                       ev_valid;
        logic [8:0]                 ev_key;
        logic                       ev_pressed;
        logic [2:0]                 n_chars;
        logic [MAX_CHARS-1:0][7:0]  chars;
    } t_cmd;

    // unshifted us keymap
    function automatic logic [7:0] plain_code(input logic [6:0] code);
        logic [7:0] c;
        unique case (code)
            7'd1:  c = 8'h1B;  7'd2:  c = 8'h31;  7'd3:  c = 8'h32;  7'd4:  c = 8'h33;
            7'd5:  c = 8'h34;  7'd6:  c = 8'h35;  7'd7:  c = 8'h36;  7'd8:  c = 8'h37;
            7'd9:  c = 8'h38;  7'd10: c = 8'h39;  7'd11: c = 8'h30;  7'd12: c = 8'h2D;
            7'd13: c = 8'h3D;  7'd14: c = 8'h08;  7'd15: c = 8'h09;  7'd16: c = 8'h71;
            7'd17: c = 8'h77;  7'd18: c = 8'h65;  7'd19: c = 8'h72;  7'd20: c = 8'h74;
            7'd21: c = 8'h79;  7'd22: c = 8'h75;  7'd23: c = 8'h69;  7'd24: c = 8'h6F;
            7'd25: c = 8'h70;  7'd26: c = 8'h5B;  7'd27: c = 8'h5D;  7'd28: c = 8'h0A;
            7'd30: c = 8'h61;  7'd31: c = 8'h73;  7'd32: c = 8'h64;  7'd33: c = 8'h66;
            7'd34: c = 8'h67;  7'd35: c = 8'h68;  7'd36: c = 8'h6A;  7'd37: c = 8'h6B;
            7'd38: c = 8'h6C;  7'd39: c = 8'h3B;  7'd40: c = 8'h27;  7'd41: c = 8'h60;
            7'd43: c = 8'h5C;  7'd44: c = 8'h7A;  7'd45: c = 8'h78;  7'd46: c = 8'h63;
            7'd47: c = 8'h76;  7'd48: c = 8'h62;  7'd49: c = 8'h6E;  7'd50: c = 8'h6D;
            7'd51: c = 8'h2C;  7'd52: c = 8'h2E;  7'd53: c = 8'h2F;  7'd55: c = 8'h2A;
            7'd57: c = 8'h20;  7'd71: c = 8'h37;  7'd72: c = 8'h38;  7'd73: c = 8'h39;
            7'd74: c = 8'h2D;  7'd75: c = 8'h34;  7'd76: c = 8'h35;  7'd77: c = 8'h36;
            7'd78: c = 8'h2B;  7'd79: c = 8'h31;  7'd80: c = 8'h32;  7'd81: c = 8'h33;
            7'd82: c = 8'h30;  7'd83: c = 8'h2E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // shifted us keymap: letters upper case, symbol row and punctuation remapped
    function automatic logic [7:0] shift_code(input logic [6:0] code);
        logic [7:0] base;
        logic [7:0] c;
        base = plain_code(code);
        unique case (code)
            7'd2:  c = 8'h21;  7'd3:  c = 8'h40;  7'd4:  c = 8'h23;  7'd5:  c = 8'h24;
            7'd6:  c = 8'h25;  7'd7:  c = 8'h5E;  7'd8:  c = 8'h26;  7'd9:  c = 8'h2A;
            7'd10: c = 8'h28;  7'd11: c = 8'h29;  7'd12: c = 8'h5F;  7'd13: c = 8'h2B;
            7'd26: c = 8'h7B;  7'd27: c = 8'h7D;  7'd39: c = 8'h3A;  7'd40: c = 8'h22;
            7'd41: c = 8'h7E;  7'd43: c = 8'h7C;  7'd51: c = 8'h3C;  7'd52: c = 8'h3E;
            7'd53: c = 8'h3F;
            default: begin
                if (base >= CH_A_LOWER && base <= CH_Z_LOWER) c = base - CH_CASE_BIAS;
                else c = base;
            end
        endcase
        return c;
    endfunction

endpackage

/* design/scancode_to_keys_decoder.sv */
// top level of the scan code set 1 to key event and character decoder
// Scan code set 1 decoder. Each accepted input word is one raw scan byte (bit 7 marks a
// release, 0xE0 is the extended prefix). The front end tracks the prefix and the shift,
// ctrl, alt and meta keys and turns every byte into a run command; a two-entry queue
// holds commands while the back end plays them out. The back end sends one result word
// per cycle while the output is ready: an optional key event first (tuser high, tdata
// holds the key code, the unshifted table code or 256..262 for up, down, right, left,
// home, end, delete, and the press flag), then zero to four character words (tuser low);
// tlast marks the final word of a byte. Bytes that give no result (prefix, modifiers,
// swallowed keys) never reach the output. A byte with k results keeps the back end busy
// until its k words have left; the next command is taken from the queue as the last word
// leaves. The first result of a byte passes through the queue and the back end's command
// register before it is on the output, and leaves as soon as the output is ready. Input
// is taken while the queue has room, even when the output is stalled.
module scancode_to_keys_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] scan_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [8:0] value, [9] pressed, [15:10] zero
    output logic        o_m_axis_tuser,   // [0] kind: 1 key event, 0 character
    output logic        o_m_axis_tlast    // last word caused by this scan byte
);
    import scd_pkg::*;

    // front to queue
    t_cmd front_cmd;
    logic front_push;
    logic q_full;

    // queue to back
    t_cmd q_cmd;
    logic q_valid;
    logic q_pop;

    // result word fields
    logic [8:0] out_value;
    logic       out_pressed;

    scd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_byte   (i_s_axis_tdata),
        .o_ready  (o_s_axis_tready),
        .i_q_full (q_full),
        .o_push   (front_push),
        .o_cmd    (front_cmd)
    );

    scd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    scd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_kind    (o_m_axis_tuser),
        .o_value   (out_value),
        .o_pressed (out_pressed),
        .o_last    (o_m_axis_tlast)
    );

    // pack value and press flag, pad to two bytes
    assign o_m_axis_tdata = {6'b000000, out_pressed, out_value};

endmodule

/* design/scd_front.sv */
// front end: accepts scan bytes, tracks modifiers and turns each byte into a run command
module scd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output scd_pkg::t_cmd     o_cmd
);
    import scd_pkg::*;

    logic r_shift, r_ctrl, r_alt, r_meta, r_chord, r_prefix;
    logic n_shift, n_ctrl, n_alt, n_meta, n_chord, n_prefix;
    t_cmd cmd;
    logic [6:0] code;
    logic rel, ext, fire, nav_hit, tap;
    logic [8:0] nav_key;
    logic [7:0] nav_fin, base, chr;

    assign code    = i_byte[6:0];
    assign rel     = i_byte[7];
    assign ext     = r_prefix;
    assign o_ready = !i_q_full;
    assign fire    = i_valid && o_ready;
    assign base    = plain_code(code);
    assign chr     = r_shift ? shift_code(code) : base;
    assign tap     = r_meta && !r_chord;

    always_comb begin
        nav_hit = 1'b1;
        nav_key = KEY_UP;
        nav_fin = CH_FIN_UP;
        unique case (code)
            SC_UP:    begin nav_key = KEY_UP;    nav_fin = CH_FIN_UP;    end
            SC_DOWN:  begin nav_key = KEY_DOWN;  nav_fin = CH_FIN_DOWN;  end
            SC_RIGHT: begin nav_key = KEY_RIGHT; nav_fin = CH_FIN_RIGHT; end
            SC_LEFT:  begin nav_key = KEY_LEFT;  nav_fin = CH_FIN_LEFT;  end
            SC_HOME:  begin nav_key = KEY_HOME;  nav_fin = CH_FIN_HOME;  end
            SC_END:   begin nav_key = KEY_END;   nav_fin = CH_FIN_END;   end
            SC_DEL:   begin nav_key = KEY_DEL;   nav_fin = CH_FIN_DEL;   end
            default:  nav_hit = 1'b0;
        endcase
    end

    always_comb begin
        cmd      = '0;
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_alt    = r_alt;
        n_meta   = r_meta;
        n_chord  = r_chord;
        n_prefix = 1'b0;
        if (i_byte == SC_PREFIX) begin
            n_prefix = 1'b1;
        end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            n_shift = !rel;
        end else if (code == SC_CTRL) begin
            n_ctrl = !rel;
        end else if (code == SC_ALT) begin
            n_alt = !rel;
        end else if (ext && (code == SC_LMETA || code == SC_RMETA)) begin
            n_meta  = !rel;
            n_chord = 1'b0;
            if (rel && tap) begin
                cmd.n_chars  = 3'd1;
                cmd.chars[0] = CH_META_TAP;
            end
        end else if (!ext && r_ctrl && r_alt && code == SC_ESC) begin
            if (!rel) begin
                cmd.n_chars  = 3'd1;
                cmd.chars[0] = CH_CAE;
            end
        end else if (!ext && r_alt && code == SC_F4) begin
            if (!rel) begin
                cmd.n_chars  = 3'd1;
                cmd.chars[0] = CH_ALT_F4;
            end
        end else if (ext && r_meta) begin
            if (!rel) begin
                n_chord = 1'b1;
                cmd.n_chars = 3'd1;
                unique case (code)
                    SC_LEFT:  cmd.chars[0] = CH_META_LEFT;
                    SC_RIGHT: cmd.chars[0] = CH_META_RIGHT;
                    SC_UP:    cmd.chars[0] = CH_META_UP;
                    SC_DOWN:  cmd.chars[0] = CH_META_DOWN;
                    default:  cmd.n_chars  = 3'd0;
                endcase
            end
        end else if (r_meta) begin
            if (!rel) n_chord = 1'b1;
        end else if (ext) begin
            if (nav_hit) begin
                cmd.ev_valid   = 1'b1;
                cmd.ev_key     = nav_key;
                cmd.ev_pressed = !rel;
                if (!rel) begin
                    cmd.chars[0] = CH_ESC;
                    cmd.chars[1] = CH_LBRACKET;
                    cmd.chars[2] = nav_fin;
                    cmd.chars[3] = CH_TILDE;
                    cmd.n_chars  = (code == SC_DEL) ? 3'd4 : 3'd3;
                end
            end
        end else begin
            // plain key: event on nonzero table code, then at most one character
            cmd.ev_valid   = (base != 8'h00);
            cmd.ev_key     = {1'b0, base};
            cmd.ev_pressed = !rel;
            if (!rel && chr != 8'h00) begin
                cmd.n_chars = 3'd1;
                if (r_alt) begin
                    cmd.chars[0] = r_shift ? CH_ALT_STAB : CH_ALT_TAB;
                    if (base != CH_TAB) cmd.n_chars = 3'd0;
                end else if (r_ctrl) begin
                    priority if (base == CH_SPACE) cmd.chars[0] = CH_CTRL_SPACE;
                    else if (base >= CH_A_LOWER && base <= CH_Z_LOWER)
                        cmd.chars[0] = base - CH_CTRL_BIAS;
                    else if (base == CH_LBRACKET)  cmd.chars[0] = CH_CTRL_LBR;
                    else if (base == CH_BACKSLASH) cmd.chars[0] = CH_CTRL_BSL;
                    else if (base == CH_RBRACKET)  cmd.chars[0] = CH_CTRL_RBR;
                    else cmd.n_chars = 3'd0;
                end else begin
                    cmd.chars[0] = chr;
                end
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = fire && (cmd.ev_valid || cmd.n_chars != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
            r_alt    <= 1'b0;
            r_meta   <= 1'b0;
            r_chord  <= 1'b0;
            r_prefix <= 1'b0;
        end else if (fire) begin
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
            r_alt    <= n_alt;
            r_meta   <= n_meta;
            r_chord  <= n_chord;
            r_prefix <= n_prefix;
        end
    end

endmodule

/* design/scd_queue.sv */
// short command queue between front end and back end
`include "scancode_to_keys_decoder_macros.svh"
module scd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scd_pkg::t_cmd     i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output scd_pkg::t_cmd     o_data
);
    import scd_pkg::*;

    t_cmd r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= ptr_inc(r_wr);
            if (i_pop)  r_rd <= ptr_inc(r_rd);
            if (i_push && !i_pop)      r_count <= r_count + QCNT_W'(1);
            else if (!i_push && i_pop) r_count <= r_count - QCNT_W'(1);
        end
    end

    `SCD_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QDEPTH))
    `SCD_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)
    `SCD_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop,
                     r_count == $past(r_count) + QCNT_W'(1))

endmodule

/* design/scd_back.sv */
// back end: expands each run command into result words, one per cycle while the output is ready
`include "scancode_to_keys_decoder_macros.svh"
module scd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  scd_pkg::t_cmd     i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [8:0]        o_value,
    output logic              o_pressed,
    output logic              o_last
);
    import scd_pkg::*;

    t_cmd r_cmd;
    logic r_busy;
    logic [2:0] r_idx;
    logic [2:0] total, cidx;
    logic is_event, fire, done;

    assign total    = {2'b00, r_cmd.ev_valid} + r_cmd.n_chars;
    assign is_event = r_cmd.ev_valid && (r_idx == 3'd0);
    assign cidx     = r_idx - {2'b00, r_cmd.ev_valid};

    assign o_valid   = r_busy;
    assign o_kind    = is_event;
    assign o_value   = is_event ? r_cmd.ev_key : {1'b0, r_cmd.chars[cidx[CIDX_W-1:0]]};
    assign o_pressed = is_event && r_cmd.ev_pressed;
    assign o_last    = (r_idx == total - 3'd1);

    assign fire    = r_busy && i_ready;
    assign done    = fire && o_last;
    assign o_q_pop = i_q_valid && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cmd <= i_q_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (fire) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    `SCD_ASSERT_IMPL(a_idx_in_run, i_clk, i_rst_n, r_busy, r_idx < total)
    `SCD_ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, r_busy && !i_ready, r_busy)
    `SCD_ASSERT_NEXT(a_stall_holds_word, i_clk, i_rst_n, r_busy && !i_ready,
                     o_value == $past(o_value) && o_kind == $past(o_kind) && o_last == $past(o_last))

endmodule
